### design/gtss_pkg.sv
// Shared types and constants for the GUID text stream scanner.
// Used by the front end, the result queue, the output stage and the top level.
// No dependencies.
package gtss_pkg;

    // Window geometry: braced form and bare form lengths in bytes.
    localparam int WIN_LEN  = 38;
    localparam int BARE_LEN = 36;
    localparam int FILL_W   = $clog2(WIN_LEN + 1);

    // Result queue geometry.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One parsed GUID, fields in reverse text order after the braced flag.
    typedef struct packed {
        logic        was_braced;
        logic [63:0] tail_bytes;
        logic [15:0] third_group;
        logic [15:0] second_group;
        logic [31:0] first_group;
    } t_rec;

    // Front-end bookkeeping, exported for checking.
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [FILL_W-1:0] skip;
    } t_front_sts;

endpackage

### design/gtss_front.sv
// Front end of the GUID text stream scanner: byte window, character
// classification, match search and skip tracking. Pushes matches to the queue.
// Depends on gtss_pkg.
module gtss_front import gtss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_q_full,
    output logic       o_push,
    output t_rec       o_rec,
    output t_front_sts o_sts
);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    // Classified byte: only these properties are ever looked at.
    typedef struct packed {
        logic       hex;
        logic       dash;
        logic       lbr;
        logic       rbr;
        logic [3:0] nib;
    } t_cls;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r      = '0;
        r.dash = (c == CH_DASH);
        r.lbr  = (c == CH_LBRACE);
        r.rbr  = (c == CH_RBRACE);
        if (c >= 8'h30 && c <= 8'h39) begin
            r.hex = 1'b1;
            r.nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.hex = 1'b1;
            r.nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.hex = 1'b1;
            r.nib = 4'(c - 8'h37);
        end
        return r;
    endfunction

    function automatic logic dash_pos(input int i);
        return (i == 8) || (i == 13) || (i == 18) || (i == 23);
    endfunction

    // Text offset of hex digit d within the bare form.
    function automatic int digit_pos(input int d);
        int p;
        if (d < 8)       p = d;
        else if (d < 12) p = d + 1;
        else if (d < 16) p = d + 2;
        else if (d < 20) p = d + 3;
        else             p = d + 4;
        return p;
    endfunction

    t_cls              r_win [WIN_LEN];
    t_cls              n_win [WIN_LEN];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_skip;
    logic [FILL_W-1:0] n_skip;
    t_cls              cls_in;
    logic              accept;
    logic [2:0]        bare_ok;
    logic              frame;
    logic [1:0]        tries;
    logic              found;
    logic [1:0]        base;
    logic              braced;
    logic [3:0]        dig [32];

    assign cls_in  = classify(i_byte);
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Insert the new byte: append while filling, shift once full.
    always_comb begin
        if (r_fill < FILL_W'(WIN_LEN)) begin
            n_fill = r_fill + 1'b1;
            for (int j = 0; j < WIN_LEN; j++) begin
                n_win[j] = (FILL_W'(j) == r_fill) ? cls_in : r_win[j];
            end
        end else begin
            n_fill = r_fill;
            for (int j = 0; j < WIN_LEN - 1; j++) begin
                n_win[j] = r_win[j + 1];
            end
            n_win[WIN_LEN-1] = cls_in;
        end
    end

    // Bare-form check at the three window offsets that fit 36 bytes.
    always_comb begin
        for (int b = 0; b < 3; b++) begin
            bare_ok[b] = 1'b1;
            for (int i = 0; i < BARE_LEN; i++) begin
                if (dash_pos(i)) begin
                    bare_ok[b] = bare_ok[b] & n_win[b + i].dash;
                end else begin
                    bare_ok[b] = bare_ok[b] & n_win[b + i].hex;
                end
            end
        end
        frame = (n_fill == FILL_W'(WIN_LEN)) && n_win[0].lbr && n_win[WIN_LEN-1].rbr;
    end

    // Positions to try: one per beat once full, the whole tail on the last beat.
    always_comb begin
        if (i_last) begin
            tries = (n_fill >= FILL_W'(BARE_LEN)) ? 2'(n_fill - FILL_W'(BARE_LEN - 1)) : 2'd0;
        end else begin
            tries = (n_fill == FILL_W'(WIN_LEN)) ? 2'd1 : 2'd0;
        end
    end

    // Walk the positions in order, consuming the skip count first.
    always_comb begin
        n_skip = r_skip;
        found  = 1'b0;
        base   = 2'd0;
        braced = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < tries) begin
                if (n_skip != '0) begin
                    n_skip = n_skip - 1'b1;
                end else if (k == 0 && frame) begin
                    // A complete brace frame allows only the braced form here.
                    if (bare_ok[1] && !found) begin
                        found  = 1'b1;
                        base   = 2'd1;
                        braced = 1'b1;
                        n_skip = FILL_W'(WIN_LEN - 1);
                    end
                end else if (bare_ok[k] && !found) begin
                    found  = 1'b1;
                    base   = 2'(k);
                    braced = 1'b0;
                    n_skip = FILL_W'(BARE_LEN - 1);
                end
            end
        end
    end

    // Gather the 32 hex digits from the matched offset.
    always_comb begin
        for (int d = 0; d < 32; d++) begin
            case (base)
                2'd0:    dig[d] = n_win[digit_pos(d)].nib;
                2'd1:    dig[d] = n_win[digit_pos(d) + 1].nib;
                default: dig[d] = n_win[digit_pos(d) + 2].nib;
            endcase
        end
    end

    // Assemble the fields, first digit most significant.
    always_comb begin
        o_rec            = '0;
        o_rec.was_braced = braced;
        for (int d = 0; d < 8; d++) begin
            o_rec.first_group[31 - 4*d -: 4] = dig[d];
        end
        for (int d = 0; d < 4; d++) begin
            o_rec.second_group[15 - 4*d -: 4] = dig[8 + d];
            o_rec.third_group[15 - 4*d -: 4]  = dig[12 + d];
        end
        for (int d = 0; d < 16; d++) begin
            o_rec.tail_bytes[63 - 4*d -: 4] = dig[16 + d];
        end
    end

    assign o_push     = accept && found;
    assign o_sts.fill = r_fill;
    assign o_sts.skip = r_skip;

    // Fill and skip counters; the last beat starts a fresh stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_skip <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_fill <= '0;
                r_skip <= '0;
            end else begin
                r_fill <= n_fill;
                r_skip <= n_skip;
            end
        end
    end

    // Window contents; entries past the fill count are never examined.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

### design/gtss_fifo.sv
// Short result queue between the scanner front end and the output stage.
// Holds parsed GUID records so either side can stall on its own.
// Depends on gtss_pkg.
module gtss_fifo import gtss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_rec o_rec
);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

### design/gtss_back.sv
// Output stage of the GUID text stream scanner: pulls records from the
// queue into an output register and presents them as stream beats.
// Depends on gtss_pkg.
module gtss_back import gtss_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_empty,
    input  t_rec         i_q_rec,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [127:0] o_data,   // tail_bytes, third_group, second_group, first_group
    output logic [0:0]   o_user    // was_braced
);

    logic r_valid;
    t_rec r_rec;

    // Refill the output register when it is empty or being taken.
    assign o_pop   = !i_q_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = {r_rec.tail_bytes, r_rec.third_group, r_rec.second_group,
                      r_rec.first_group};
    assign o_user  = r_rec.was_braced;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_q_rec;
        end
    end

endmodule

### design/guid_text_stream_scanner.sv
// GUID text stream scanner: takes one text byte per beat (tlast ends a stream)
// and emits one beat for every GUID found, braced {8-4-4-4-12} or bare
// 8-4-4-4-12 with hex digits of either case, scanned leftmost and without
// overlap. A position is tried once the 38 bytes from it have arrived, and the
// last beat of a stream also tries the tail positions with 36 or 37 bytes left
// before the window, fill count and skip count start over. The block takes one
// byte every clock while the result queue has room; the whole window check for
// a beat is done in the cycle that accepts it, the match is written to the
// result queue at that edge, and the output register then takes the GUID from
// the queue and presents it. Input stalls only while the two-entry result queue
// is full, which happens only when the output side holds tready low.
module guid_text_stream_scanner import gtss_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // end_of_stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // tail_bytes, third_group, second_group, first_group
    output logic [0:0]   m_axis_tuser    // was_braced
);

    logic       q_push;
    t_rec       q_in;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    t_rec       q_out;
    t_front_sts sts;

    // Window, classification and match search.
    gtss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_rec    (q_in),
        .o_sts    (sts)
    );

    // Result queue.
    gtss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (q_out)
    );

    // Output register.
    gtss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_rec   (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser)
    );

    // A match is never dropped for lack of queue space.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("result pushed into a full queue");

    // The last beat of a stream leaves the scanner empty.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
            (sts.fill == '0 && sts.skip == '0))
        else $error("scanner state not cleared after last beat");

    // Skipped positions are only pending while the window is full.
    a_skip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sts.skip != '0) |-> (sts.fill == FILL_W'(WIN_LEN)))
        else $error("skip count pending with a partial window");

endmodule
